/* rtl/core/contiguous_block_allocator_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous block allocator
// Each macro places one labeled concurrent assertion on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define CBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cba_pkg.sv */
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the contiguous block allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cba_pkg;

  localparam int NUM_BLOCKS      = 1024;
  localparam int RESERVED_BLOCKS = 1;

  // Map word geometry: the used map is stored one word of blocks per entry.
  localparam int WORD_W    = 32;
  localparam int MAP_WORDS = NUM_BLOCKS / WORD_W;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int WADDR_W   = $clog2(MAP_WORDS);

  // Field widths.
  localparam int BLK_W    = 10;
  localparam int LEN_W    = 11;
  localparam int STATUS_W = 2;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

  typedef struct packed {
    logic             action;
    logic [LEN_W-1:0] run_length;
    logic [BLK_W-1:0] first_block;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]    granted_block;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_APPLY = 5'b01000,
    ST_RESP  = 5'b10000
  } state_t;

endpackage

/* rtl/core/cba_ram.sv */
// ----------------------------------------------------------------------------
// cba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/contiguous_block_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// First-fit allocator of contiguous block runs over a one-bit used map.
// ----------------------------------------------------------------------------
// The used map lives in a 32-entry by 32-bit RAM, one word of blocks per
// entry. After reset a clearing pass over every word writes the reset pattern
// (reserved leading blocks used, rest free); req_ready stays low meanwhile.
// An allocate request reads the map one word per cycle from block 0, tracking
// the length of the current free run across words; the first word in which
// the run reaches the requested length ends the scan. The run is then marked
// in a read-modify-write sweep of one word per cycle. A release sweeps the
// words of its range the same way. This word-at-a-time pace is set by the
// single RAM read port. A zero length or out-of-range request goes
// straight to the result without touching the map, and a result still
// waiting in the output register holds the next one back in ST_RESP.
// A new request is taken only in idle, while the previous result may
// still wait in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module contiguous_block_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cba_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cba_pkg::rsp_t rsp
);
  import cba_pkg::*;

  state_t                state;
  logic [WADDR_W-1:0]    init_addr;
  logic [WADDR_W-1:0]    scan_word;
  logic [WADDR_W-1:0]    apply_word;
  logic [LEN_W-1:0]      scan_count;
  logic [LEN_W-1:0]      op_len;
  logic [BLK_W-1:0]      op_lo;
  logic [BLK_W-1:0]      op_hi;
  logic                  op_set;
  logic [STATUS_W-1:0]   res_status;
  logic [BLK_W-1:0]      res_block;

  logic                  ram_we;
  logic [WADDR_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WADDR_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  logic [LEN_W:0]        rel_end;
  logic                  rel_oob;
  logic [BLK_W-1:0]      rel_hi;
  logic                  hit;
  logic [BIT_W-1:0]      hit_bit;
  logic [LEN_W-1:0]      cnt_top;
  logic [BLK_W-1:0]      hit_blk;
  logic [BLK_W-1:0]      alloc_lo;
  logic [WORD_W-1:0]     init_pattern;
  logic [WORD_W-1:0]     apply_mask;
  logic                  rsp_free;

  // Free-run length ending at bit b of a word: distance to the last used bit
  // at or below b, or the carried run plus b+1 when the word is free up to b.
  function automatic logic [LEN_W-1:0] run_end(input logic [WORD_W-1:0] used,
                                               input int b,
                                               input logic [LEN_W-1:0] carry);
    logic [LEN_W-1:0] r;
    r = carry + LEN_W'(b) + LEN_W'(1);
    for (int k = 0; k < WORD_W; k++) begin
      if (k <= b && used[k]) begin
        r = LEN_W'(b - k);
      end
    end
    return r;
  endfunction

  cba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_ready = (state == ST_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;

  // Release range check: first + length must not pass the end of the map.
  assign rel_end = (LEN_W+1)'(req.first_block) + (LEN_W+1)'(req.run_length);
  assign rel_oob = rel_end > (LEN_W+1)'(NUM_BLOCKS);
  assign rel_hi  = BLK_W'(rel_end - (LEN_W+1)'(1));

  // Scan the word in hand; the lowest bit where the run reaches op_len wins.
  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (run_end(ram_rdata, b, scan_count) >= op_len) begin
        hit     = 1'b1;
        hit_bit = BIT_W'(b);
      end
    end
  end

  assign cnt_top  = run_end(ram_rdata, WORD_W - 1, scan_count);
  assign hit_blk  = {scan_word, hit_bit};
  assign alloc_lo = BLK_W'((LEN_W+1)'(hit_blk) + (LEN_W+1)'(1) - (LEN_W+1)'(op_len));

  // Reset contents of the word under the clearing pass.
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      init_pattern[b] = (LEN_W)'({init_addr, BIT_W'(b)}) < LEN_W'(RESERVED_BLOCKS);
    end
  end

  // Bits of the current word that fall inside [op_lo, op_hi].
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      apply_mask[b] =
        ((apply_word != op_lo[BLK_W-1 -: WADDR_W]) || (BIT_W'(b) >= op_lo[BIT_W-1:0])) &&
        ((apply_word != op_hi[BLK_W-1 -: WADDR_W]) || (BIT_W'(b) <= op_hi[BIT_W-1:0]));
    end
  end

  // Write side: reset pattern during the clearing pass, else set or clear the
  // masked bits of the word read in the previous cycle.
  assign ram_we    = (state == ST_INIT) || (state == ST_APPLY);
  assign ram_waddr = (state == ST_INIT) ? init_addr : apply_word;
  assign ram_wdata = (state == ST_INIT) ? init_pattern :
                     op_set ? (ram_rdata | apply_mask) : (ram_rdata & ~apply_mask);

  // Read side: in idle, scan and apply, fetch the word the next cycle will work on.
  always_comb begin
    case (state)
      ST_IDLE: begin
        ram_raddr = (req.action == ACT_RELEASE) ? req.first_block[BLK_W-1 -: WADDR_W] : '0;
      end
      ST_SCAN: begin
        ram_raddr = hit ? alloc_lo[BLK_W-1 -: WADDR_W] : scan_word + 1'b1;
      end
      ST_APPLY: begin
        ram_raddr = apply_word + 1'b1;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      init_addr <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the result once taken; in ST_RESP the load below handles it.
      if (rsp_valid && rsp_ready && (state != ST_RESP)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          init_addr <= init_addr + 1'b1;
          if (init_addr == WADDR_W'(MAP_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            op_len     <= req.run_length;
            scan_count <= '0;
            scan_word  <= '0;
            res_block  <= '0;
            if (req.action == ACT_ALLOC) begin
              if (req.run_length == '0) begin
                res_status <= STATUS_NO_SPACE;
                state      <= ST_RESP;
              end else begin
                state <= ST_SCAN;
              end
            end else if (rel_oob) begin
              res_status <= STATUS_RANGE;
              state      <= ST_RESP;
            end else if (req.run_length == '0) begin
              res_status <= STATUS_OK;
              state      <= ST_RESP;
            end else begin
              op_lo      <= req.first_block;
              op_hi      <= rel_hi;
              op_set     <= 1'b0;
              apply_word <= req.first_block[BLK_W-1 -: WADDR_W];
              res_status <= STATUS_OK;
              state      <= ST_APPLY;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            op_lo      <= alloc_lo;
            op_hi      <= hit_blk;
            op_set     <= 1'b1;
            apply_word <= alloc_lo[BLK_W-1 -: WADDR_W];
            res_status <= STATUS_OK;
            res_block  <= alloc_lo;
            state      <= ST_APPLY;
          end else if (scan_word == WADDR_W'(MAP_WORDS - 1)) begin
            res_status <= STATUS_NO_SPACE;
            state      <= ST_RESP;
          end else begin
            // Advance, carrying the free run that ends at the top of this word.
            scan_word  <= scan_word + 1'b1;
            scan_count <= cnt_top;
          end
        end
        ST_APPLY: begin
          if (apply_word == op_hi[BLK_W-1 -: WADDR_W]) begin
            state <= ST_RESP;
          end else begin
            apply_word <= apply_word + 1'b1;
          end
        end
        ST_RESP: begin
          // Hold the result until the output register is free.
          if (rsp_free) begin
            rsp_valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.granted_block <= res_block;
            state             <= ST_IDLE;
          end else begin
            rsp_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "contiguous_block_allocator_assert.svh"

  `CBA_ASSERT_NOW(a_write_phase, ram_we, (state == ST_INIT) || (state == ST_APPLY), "map written outside init or apply")
  `CBA_ASSERT_NOW(a_grant_only_ok, rsp_valid, (rsp.status == STATUS_OK) || (rsp.granted_block == '0), "granted block set on a failed result")
  `CBA_ASSERT_NOW(a_scan_below_len, state == ST_SCAN, scan_count < op_len, "carried run reached length without a hit")
  `CBA_ASSERT_NEXT(a_resp_load, (state == ST_RESP) && rsp_free, rsp_valid && (state == ST_IDLE), "result not loaded when output free")

endmodule
